[src/cisx_pkg.sv]
// Shared types and constants for the CAN identifier interval statistics block.
// Used by the cell chain, the divider and the top level; depends on nothing.
`timescale 1ns / 1ps
package cisx_pkg;

    localparam int ID_W    = 29;
    localparam int TS_W    = 40;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 48;
    localparam int PROTO_W = 4;
    localparam int BYTE_W  = 35;

    // Search token that walks down the cell chain, one cell per cycle.
    typedef struct packed {
        logic             vld;
        logic             found;
        logic             free_seen;
        logic [ID_W-1:0]  id;
        logic [TS_W-1:0]  ts;
        logic [CNT_W-1:0] cnt;
        logic [TS_W-1:0]  mn;
        logic [TS_W-1:0]  mx;
        logic [SUM_W-1:0] sum;
    } tok_t;

    // Allocation command broadcast to the claiming cell.
    typedef struct packed {
        logic            go;
        logic [ID_W-1:0] id;
        logic [TS_W-1:0] ts;
    } alloc_t;

endpackage

[src/can_id_interval_stats_top.sv]
// Top level of the CAN identifier interval statistics block: control, cell chain, divider.
// Depends on cisx_pkg, cisx_cell and cisx_div.
`timescale 1ns / 1ps
// A frame is taken when start is high and busy is low; frames whose protocol differs
// from the configured CAN code are dropped at once and leave busy low. A CAN frame
// holds busy while a search token walks the chain of ENTRIES cells, one cell per
// cycle. When the identifier has two or more frames, a bit-serial divider then
// works out the average interval before the result is given. The single result is
// shown for one cycle with done high; the receiver cannot stall it. The table is
// empty after reset with no clearing pass.
module can_id_interval_stats_top #(
    parameter int ENTRIES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [cisx_pkg::PROTO_W-1:0] cfg_wdata,
    input  logic                         start,
    output logic                         busy,
    input  logic [cisx_pkg::PROTO_W-1:0] protocol,
    input  logic [cisx_pkg::ID_W-1:0]    frame_id,
    input  logic [cisx_pkg::TS_W-1:0]    timestamp_us,
    output logic                         done,
    output logic [cisx_pkg::ID_W-1:0]    out_id,
    output logic [cisx_pkg::CNT_W-1:0]   frame_count,
    output logic [cisx_pkg::BYTE_W-1:0]  byte_estimate,
    output logic [cisx_pkg::TS_W-1:0]    min_interval_us,
    output logic [cisx_pkg::TS_W-1:0]    max_interval_us,
    output logic [cisx_pkg::TS_W-1:0]    avg_interval_us,
    output logic                         table_full
);
    import cisx_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [PROTO_W-1:0] code_reg;
    tok_t               head_reg;
    tok_t               tok [0:ENTRIES];
    tok_t               tail;
    alloc_t             alloc;

    logic               done_reg;
    logic [ID_W-1:0]    id_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TS_W-1:0]    mn_reg;
    logic [TS_W-1:0]    mx_reg;
    logic [TS_W-1:0]    avg_reg;
    logic               full_reg;

    logic               accept;
    logic               div_start;
    logic               div_done;
    logic [SUM_W-1:0]   quot;

    assign accept = start && (state_reg == S_IDLE) && (protocol == code_reg);
    assign tail   = tok[ENTRIES];
    assign tok[0] = head_reg;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            cisx_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok[g]),
                .alloc   (alloc),
                .tok_out (tok[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        alloc.go  = (state_reg == S_SCAN) && tail.vld && !tail.found && tail.free_seen;
        alloc.id  = head_reg.id;
        alloc.ts  = head_reg.ts;
        div_start = (state_reg == S_SCAN) && tail.vld && tail.found && (tail.cnt >= CNT_W'(2));
    end

    cisx_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tail.sum),
        .divisor  (tail.cnt - 1'b1),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_SCAN;
            S_SCAN:
                if (tail.vld)
                    state_next = div_start ? S_DIV : S_IDLE;
            S_DIV:
                if (div_done)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= '0;
            head_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg.vld <= accept;
            // hold the frame in the head register: it also feeds the allocation write
            if (accept)
            begin
                head_reg.found     <= 1'b0;
                head_reg.free_seen <= 1'b0;
                head_reg.id        <= frame_id;
                head_reg.ts        <= timestamp_us;
                head_reg.cnt       <= '0;
                head_reg.mn        <= '0;
                head_reg.mx        <= '0;
                head_reg.sum       <= '0;
            end
            if (cfg_we)
                code_reg <= cfg_wdata;
            done_reg <= ((state_reg == S_SCAN) && tail.vld && !div_start)
                        || ((state_reg == S_DIV) && div_done);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            id_reg <= frame_id;
        if ((state_reg == S_SCAN) && tail.vld)
        begin
            avg_reg <= '0;
            if (tail.found)
            begin
                full_reg <= 1'b0;
                cnt_reg  <= tail.cnt;
                mn_reg   <= (tail.cnt >= CNT_W'(2)) ? tail.mn : '0;
                mx_reg   <= (tail.cnt >= CNT_W'(2)) ? tail.mx : '0;
            end
            else
            begin
                full_reg <= !tail.free_seen;
                cnt_reg  <= tail.free_seen ? CNT_W'(1) : '0;
                mn_reg   <= '0;
                mx_reg   <= '0;
            end
        end
        else if ((state_reg == S_DIV) && div_done)
        begin
            // saturate the quotient to the output width
            avg_reg <= (|quot[SUM_W-1:TS_W]) ? '1 : quot[TS_W-1:0];
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign out_id          = id_reg;
    assign frame_count     = cnt_reg;
    assign byte_estimate   = {cnt_reg, 3'b000};
    assign min_interval_us = mn_reg;
    assign max_interval_us = mx_reg;
    assign avg_interval_us = avg_reg;
    assign table_full      = full_reg;

endmodule

[src/cisx_cell.sv]
// One table entry of the identifier chain: holds its statistics and passes the token on.
// Depends on cisx_pkg.
`timescale 1ns / 1ps
module cisx_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  cisx_pkg::tok_t   tok_in,
    input  cisx_pkg::alloc_t alloc,
    output cisx_pkg::tok_t   tok_out
);
    import cisx_pkg::*;

    logic             valid_reg;
    logic             claim_reg;
    logic             claim_next;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic [ID_W-1:0]  ident_reg;
    logic [TS_W-1:0]  last_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [TS_W-1:0]  mn_reg;
    logic [TS_W-1:0]  mx_reg;
    logic [SUM_W-1:0] sum_reg;

    logic             hit;
    logic [TS_W:0]    diff;
    logic [TS_W-1:0]  gap;
    logic [SUM_W:0]   sum_ext;
    logic [SUM_W-1:0] sum_new;
    logic [CNT_W-1:0] cnt_new;
    logic [TS_W-1:0]  mn_new;
    logic [TS_W-1:0]  mx_new;

    always_comb
    begin
        hit     = tok_in.vld && !tok_in.found && valid_reg && (ident_reg == tok_in.id);
        diff    = {1'b0, tok_in.ts} - {1'b0, last_reg};
        // clamp a backward step in time to zero
        gap     = diff[TS_W] ? '0 : diff[TS_W-1:0];
        sum_ext = {1'b0, sum_reg} + {{(SUM_W-TS_W+1){1'b0}}, gap};
        sum_new = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        cnt_new = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;
        if (cnt_reg < CNT_W'(2))
        begin
            mn_new = gap;
            mx_new = gap;
        end
        else
        begin
            mn_new = (gap < mn_reg) ? gap : mn_reg;
            mx_new = (gap > mx_reg) ? gap : mx_reg;
        end

        tok_next   = tok_in;
        claim_next = claim_reg;
        if (tok_in.vld)
        begin
            claim_next         = !valid_reg && !tok_in.free_seen;
            tok_next.free_seen = tok_in.free_seen | !valid_reg;
        end
        if (hit)
        begin
            tok_next.found = 1'b1;
            tok_next.cnt   = cnt_new;
            tok_next.mn    = mn_new;
            tok_next.mx    = mx_new;
            tok_next.sum   = sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            claim_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg   <= tok_next;
            claim_reg <= claim_next;
            if (alloc.go && claim_reg)
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc.go && claim_reg)
        begin
            ident_reg <= alloc.id;
            last_reg  <= alloc.ts;
            cnt_reg   <= CNT_W'(1);
            mn_reg    <= '0;
            mx_reg    <= '0;
            sum_reg   <= '0;
        end
        else if (hit)
        begin
            last_reg <= tok_in.ts;
            cnt_reg  <= cnt_new;
            mn_reg   <= mn_new;
            mx_reg   <= mx_new;
            sum_reg  <= sum_new;
        end
    end

    assign tok_out = tok_reg;

endmodule

[src/cisx_div.sv]
// Restoring divider, one quotient bit per cycle, for the average interval.
// Depends on cisx_pkg.
`timescale 1ns / 1ps
module cisx_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cisx_pkg::SUM_W-1:0] dividend,
    input  logic [cisx_pkg::CNT_W-1:0] divisor,
    output logic                       done,
    output logic [cisx_pkg::SUM_W-1:0] quotient
);
    import cisx_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W:0]    trial;
    logic              take;

    always_comb
    begin
        trial = {rem_reg[CNT_W-1:0], dvd_reg[SUM_W-1]};
        take  = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? (trial - {1'b0, dvs_reg}) : trial;
            dvd_reg <= {dvd_reg[SUM_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

[tb/tb_can_id_interval_stats_top.sv]
// Testbench for can_id_interval_stats_top: per-identifier interval statistics checked
// against an in-bench predictor. Depends on cisx_pkg and the block's RTL only.
`timescale 1ns / 1ps
module tb_can_id_interval_stats_top;
    import cisx_pkg::*;

    localparam int NSLOT = 64;
    localparam logic [CNT_W-1:0] CNT_SAT = '1;
    localparam logic [SUM_W-1:0] SUM_SAT = '1;
    localparam logic [TS_W-1:0]  TS_MAX  = '1;
    localparam logic [ID_W-1:0]  ID_MAX  = '1;
    localparam int DRAIN_CYC = NSLOT + 80;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [CNT_W-1:0]  cnt;
        logic [BYTE_W-1:0] bytes;
        logic [TS_W-1:0]   mn;
        logic [TS_W-1:0]   mx;
        logic [TS_W-1:0]   avg;
        logic              full;
    } stats_t;

    typedef struct {
        logic [PROTO_W-1:0] proto;
        logic [ID_W-1:0]    id;
        logic [TS_W-1:0]    ts;
        bit                 has_exp;
        stats_t             exp;
    } frame_row_t;

    logic clk, rst_n, cfg_we, start, busy, done, table_full;
    logic [PROTO_W-1:0] cfg_wdata, protocol;
    logic [ID_W-1:0]    frame_id, out_id;
    logic [TS_W-1:0]    timestamp_us, min_interval_us, max_interval_us, avg_interval_us;
    logic [CNT_W-1:0]   frame_count;
    logic [BYTE_W-1:0]  byte_estimate;

    can_id_interval_stats_top #(.ENTRIES(NSLOT)) DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .protocol(protocol), .frame_id(frame_id),
        .timestamp_us(timestamp_us), .done(done), .out_id(out_id),
        .frame_count(frame_count), .byte_estimate(byte_estimate),
        .min_interval_us(min_interval_us), .max_interval_us(max_interval_us),
        .avg_interval_us(avg_interval_us), .table_full(table_full)
    );

    // predictor state
    logic [PROTO_W-1:0] can_code;
    bit                 slot_used [NSLOT];
    logic [ID_W-1:0]    slot_id   [NSLOT];
    logic [TS_W-1:0]    slot_last [NSLOT];
    logic [CNT_W-1:0]   slot_cnt  [NSLOT];
    logic [TS_W-1:0]    slot_min  [NSLOT];
    logic [TS_W-1:0]    slot_max  [NSLOT];
    logic [SUM_W-1:0]   slot_sum  [NSLOT];

    stats_t expected_stats[$];
    int errors, n_frames, n_results, n_full, n_back;
    logic [TS_W-1:0] wall_us;
    logic [ID_W-1:0] id_pool[$];
    frame_row_t rows[$];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #200ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic bit predict_frame(input logic [PROTO_W-1:0] p,
                                         input logic [ID_W-1:0] id,
                                         input logic [TS_W-1:0] ts,
                                         output stats_t r);
        int hit, fre;
        logic [TS_W-1:0]  gap;
        logic [SUM_W:0]   wide_sum;
        logic [SUM_W-1:0] q;
        hit = -1;
        fre = -1;
        r = '{default: '0};
        if (p != can_code) return 0;
        r.id = id;
        for (int k = 0; k < NSLOT; k++) begin
            if (slot_used[k]) begin
                if (hit < 0 && slot_id[k] == id) hit = k;
            end
            else if (fre < 0) fre = k;
        end
        if (hit < 0 && fre < 0) begin
            r.full = 1'b1;
            return 1;
        end
        if (hit < 0) begin
            hit = fre;
            slot_used[hit] = 1;
            slot_id[hit] = id;
            slot_last[hit] = ts;
            slot_cnt[hit] = 1;
            slot_min[hit] = '0;
            slot_max[hit] = '0;
            slot_sum[hit] = '0;
        end
        else begin
            gap = (ts >= slot_last[hit]) ? ts - slot_last[hit] : '0;
            if (slot_cnt[hit] < 2) begin
                slot_min[hit] = gap;
                slot_max[hit] = gap;
            end
            else begin
                if (gap < slot_min[hit]) slot_min[hit] = gap;
                if (gap > slot_max[hit]) slot_max[hit] = gap;
            end
            wide_sum = {1'b0, slot_sum[hit]} + gap;
            slot_sum[hit] = wide_sum[SUM_W] ? SUM_SAT : wide_sum[SUM_W-1:0];
            if (slot_cnt[hit] != CNT_SAT) slot_cnt[hit]++;
            slot_last[hit] = ts;
        end
        r.cnt = slot_cnt[hit];
        r.bytes = {slot_cnt[hit], 3'b000};
        if (slot_cnt[hit] >= 2) begin
            q = slot_sum[hit] / (slot_cnt[hit] - 1);
            r.mn = slot_min[hit];
            r.mx = slot_max[hit];
            r.avg = (q > TS_MAX) ? TS_MAX : q[TS_W-1:0];
        end
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    // accept results at the edge that ends their strobe cycle
    always @(posedge clk) begin
        stats_t e;
        if (rst_n && done) begin
            n_results++;
            if (expected_stats.size() == 0)
                report_mismatch("unexpected result, id", out_id, 0);
            else begin
                e = expected_stats.pop_front();
                if (out_id !== e.id) report_mismatch("out_id", out_id, e.id);
                if (frame_count !== e.cnt) report_mismatch("frame_count", frame_count, e.cnt);
                if (byte_estimate !== e.bytes)
                    report_mismatch("byte_estimate", byte_estimate, e.bytes);
                if (min_interval_us !== e.mn) report_mismatch("min", min_interval_us, e.mn);
                if (max_interval_us !== e.mx) report_mismatch("max", max_interval_us, e.mx);
                if (avg_interval_us !== e.avg) report_mismatch("avg", avg_interval_us, e.avg);
                if (table_full !== e.full) report_mismatch("table_full", table_full, e.full);
            end
        end
    end

    task automatic send_frame(input logic [PROTO_W-1:0] p, input logic [ID_W-1:0] id,
                              input logic [TS_W-1:0] ts, input bit gaps,
                              input bit has_exp, input stats_t typed);
        stats_t r;
        if (gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        protocol <= p;
        frame_id <= id;
        timestamp_us <= ts;
        do @(posedge clk); while (busy);
        n_frames++;
        if (predict_frame(p, id, ts, r)) begin
            if (r.full) n_full++;
            if (has_exp && r != typed) report_mismatch("predictor vs table row", r.cnt, typed.cnt);
            expected_stats = {expected_stats, r};
        end
        // hold start high into the next transaction; lower it only when idling or for a random gap
    endtask

    task automatic add_row(input logic [PROTO_W-1:0] p, input logic [ID_W-1:0] id,
                           input logic [TS_W-1:0] ts, input bit has_exp,
                           input stats_t exp_r);
        frame_row_t row;
        row.proto   = p;
        row.id      = id;
        row.ts      = ts;
        row.has_exp = has_exp;
        row.exp     = exp_r;
        rows = {rows, row};
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (expected_stats.size() != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_code(input logic [PROTO_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        can_code = v;
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        if (id_pool.size() != 0 && $urandom_range(0, 9) != 0)
            return id_pool[$urandom_range(0, id_pool.size() - 1)];
        return ($urandom_range(0, 1) != 0) ? ID_W'($urandom_range(0, 2047)) : ID_W'($urandom);
    endfunction

    task automatic random_phase(input int count, input bit gaps);
        logic [ID_W-1:0] id;
        logic [TS_W-1:0] ts;
        logic [PROTO_W-1:0] p;
        for (int i = 0; i < count; i++) begin
            p = ($urandom_range(0, 7) == 0) ? PROTO_W'($urandom) : can_code;
            id = pick_id();
            case ($urandom_range(0, 15))
                0: ts = TS_W'({$urandom, $urandom});
                1: begin
                    ts = wall_us - $urandom_range(0, 500);
                    n_back++;
                end
                default: begin
                    wall_us += $urandom_range(0, 300);
                    ts = wall_us;
                end
            endcase
            send_frame(p, id, ts, gaps, 0, '{default: '0});
        end
    endtask

    initial begin
        stats_t z;
        stats_t e;
        errors = 0; n_frames = 0; n_results = 0; n_full = 0; n_back = 0;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0; start = 1'b0;
        protocol = '0; frame_id = '0; timestamp_us = '0;
        can_code = '0;
        wall_us = 40'd1000;
        foreach (slot_used[k]) slot_used[k] = 0;
        z = '{default: '0};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first sight of an id, extremes, time going back, non-CAN drop
        e = z; e.id = ID_MAX; e.cnt = 1; e.bytes = 8;
        add_row(4'd0, ID_MAX, TS_MAX, 1, e);
        e = z; e.id = ID_MAX; e.cnt = 2; e.bytes = 16;
        add_row(4'd0, ID_MAX, 40'd5, 1, e);
        e = z; e.id = '0; e.cnt = 1; e.bytes = 8;
        add_row(4'd0, '0, '0, 1, e);
        e = z; e.id = '0; e.cnt = 2; e.bytes = 16; e.mn = TS_MAX; e.mx = TS_MAX; e.avg = TS_MAX;
        add_row(4'd0, '0, TS_MAX, 1, e);
        add_row(4'd15, 29'h155_5555, 40'd7, 0, z);
        add_row(4'd0, '0, TS_MAX, 0, z);
        add_row(4'd0, 29'h0AA_AAAA, 40'hAA_AAAA_AAAA, 0, z);
        add_row(4'd0, 29'h0AA_AAAA, 40'hAA_AAAA_AAB0, 0, z);
        add_row(4'd0, 29'h155_5555, 40'h55_5555_5555, 0, z);
        add_row(4'd0, 29'h155_5555, 40'h55_5555_5560, 0, z);
        foreach (rows[i])
            send_frame(rows[i].proto, rows[i].id, rows[i].ts, 0, rows[i].has_exp, rows[i].exp);
        wait_idle();

        // fill the table to overflow, then hit the full case with new ids
        for (int i = 0; i < NSLOT + 3; i++) begin
            id_pool = {id_pool, ID_W'(32'h100 + i)};
            send_frame(can_code, ID_W'(32'h100 + i), wall_us, 1, 0, z);
        end
        wait_idle();

        random_phase(400, 1);
        wait_idle();
        write_code(4'd15);
        random_phase(300, 1);
        wait_idle();
        write_code(4'd9);
        random_phase(300, 1);
        wait_idle();
        write_code(4'd0);
        random_phase(150, 0);
        wait_idle();

        $display("Covered %0d frames, %0d results, %0d table-full, %0d time reversals;",
                 n_frames, n_results, n_full, n_back);
        $display("protocol codes 0, 15 and 9 were each used as the CAN code.");
        if (errors == 0 && expected_stats.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
